// ----- rtl/core/gntw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Package for the greedy nearest tile walk: field widths, command codes and
// the command/status structs between controller and datapath. No dependencies.

package gntw_pkg;

	localparam int TILE_W     = 13;
	localparam int POS_W      = 18;
	localparam int CNT_W      = 3;
	localparam int MAX_TILES  = 8192;
	localparam int SQ_W       = 2 * POS_W;
	localparam int DIST_W     = SQ_W + 2;
	localparam int SEED_IDX_W = 4;
	localparam int SLOT_W     = 3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                  start;
		logic                  load_wr;
		logic                  nbr_rd;
		logic                  clr_moved;
		logic                  cand_vld;
		logic                  cand_first;
		logic                  cand_nbr;
		logic [SEED_IDX_W-1:0] seed_idx;
		logic [SLOT_W-1:0]     slot;
		logic                  out_load;
	} gntw_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             moved;
		logic [CNT_W-1:0] nbr_cnt;
	} gntw_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/gntw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module gntw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/gntw_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the tile walk: position and neighbor tables, distance pipeline
// and running best tile. Depends on gntw_pkg and gntw_ram.

module gntw_dp #(
	parameter int MAX_NEIGHBORS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gntw_pkg::gntw_cmd_t                 cmd,
	output gntw_pkg::gntw_stat_t                stat,
	input  logic        [gntw_pkg::TILE_W-1:0]  tile_index,
	input  logic signed [gntw_pkg::POS_W-1:0]   pos_x,
	input  logic signed [gntw_pkg::POS_W-1:0]   pos_y,
	input  logic signed [gntw_pkg::POS_W-1:0]   pos_z,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_0,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_1,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_2,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_3,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_4,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_5,
	input  logic        [gntw_pkg::CNT_W-1:0]   neighbor_count,
	output logic        [gntw_pkg::TILE_W-1:0]  nearest_tile
);

	import gntw_pkg::*;

	localparam int ROW_W = MAX_NEIGHBORS * TILE_W + CNT_W;
	localparam int POSW3 = 3 * POS_W;
	localparam logic [CNT_W-1:0] NB_MAX = CNT_W'(MAX_NEIGHBORS);

	logic [TILE_W-1:0] nb_in [6];
	logic [ROW_W-1:0]  nbr_wdata;
	logic [ROW_W-1:0]  nbr_rdata;
	logic [TILE_W-1:0] nb_rd [MAX_NEIGHBORS];
	logic [CNT_W-1:0]  cnt_raw;
	logic [CNT_W-1:0]  cnt_eff;
	logic [TILE_W-1:0] cand_tile;
	logic [POSW3-1:0]  pos_rdata;

	logic signed [POS_W-1:0] pt_x_q, pt_y_q, pt_z_q;
	logic signed [POS_W-1:0] rd_x, rd_y, rd_z;
	logic signed [POS_W:0]   dx, dy, dz;
	logic signed [2*POS_W+1:0] px, py, pz;

	logic              vld_s1, vld_s2, vld_s3;
	logic              first_s1, first_s2, first_s3;
	logic              nbr_s1, nbr_s2, nbr_s3;
	logic [TILE_W-1:0] tile_s1, tile_s2, tile_s3;
	logic [SQ_W-1:0]   sq_x_s2, sq_y_s2, sq_z_s2;
	logic [DIST_W-1:0] dist_s3;

	logic [TILE_W-1:0] cur_q;
	logic [DIST_W-1:0] cd_q;
	logic              moved_q;
	logic [TILE_W-1:0] nearest_q;
	logic              closer;

	assign nb_in[0] = neighbor_0;
	assign nb_in[1] = neighbor_1;
	assign nb_in[2] = neighbor_2;
	assign nb_in[3] = neighbor_3;
	assign nb_in[4] = neighbor_4;
	assign nb_in[5] = neighbor_5;

	always_comb begin
		nbr_wdata = '0;
		for (int j = 0; j < MAX_NEIGHBORS; j++) begin
			nbr_wdata[j*TILE_W +: TILE_W] = nb_in[j];
		end
		nbr_wdata[ROW_W-1 -: CNT_W] = neighbor_count;
	end

	always_comb begin
		for (int j = 0; j < MAX_NEIGHBORS; j++) begin
			nb_rd[j] = nbr_rdata[j*TILE_W +: TILE_W];
		end
	end

	// zero acts as one, anything above the row size as the row size
	assign cnt_raw = nbr_rdata[ROW_W-1 -: CNT_W];
	always_comb begin
		if (cnt_raw == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (cnt_raw > NB_MAX) begin
			cnt_eff = NB_MAX;
		end else begin
			cnt_eff = cnt_raw;
		end
	end

	assign cand_tile = cmd.cand_nbr ? nb_rd[cmd.slot] : TILE_W'(cmd.seed_idx);

	gntw_ram #(
		.WIDTH (POSW3),
		.DEPTH (MAX_TILES)
	) u_pos_ram (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (tile_index),
		.wdata ({pos_z, pos_y, pos_x}),
		.re    (cmd.cand_vld),
		.raddr (cand_tile),
		.rdata (pos_rdata)
	);

	gntw_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_TILES)
	) u_nbr_ram (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (tile_index),
		.wdata (nbr_wdata),
		.re    (cmd.nbr_rd),
		.raddr (cur_q),
		.rdata (nbr_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pt_x_q <= pos_x;
			pt_y_q <= pos_y;
			pt_z_q <= pos_z;
		end
	end

	assign rd_x = pos_rdata[POS_W-1:0];
	assign rd_y = pos_rdata[2*POS_W-1:POS_W];
	assign rd_z = pos_rdata[POSW3-1:2*POS_W];

	assign dx = (POS_W+1)'(pt_x_q) - (POS_W+1)'(rd_x);
	assign dy = (POS_W+1)'(pt_y_q) - (POS_W+1)'(rd_y);
	assign dz = (POS_W+1)'(pt_z_q) - (POS_W+1)'(rd_z);
	assign px = (2*POS_W+2)'(dx) * (2*POS_W+2)'(dx);
	assign py = (2*POS_W+2)'(dy) * (2*POS_W+2)'(dy);
	assign pz = (2*POS_W+2)'(dz) * (2*POS_W+2)'(dz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.cand_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.cand_first;
		nbr_s1   <= cmd.cand_nbr;
		tile_s1  <= cand_tile;
		first_s2 <= first_s1;
		nbr_s2   <= nbr_s1;
		tile_s2  <= tile_s1;
		sq_x_s2  <= px[SQ_W-1:0];
		sq_y_s2  <= py[SQ_W-1:0];
		sq_z_s2  <= pz[SQ_W-1:0];
		first_s3 <= first_s2;
		nbr_s3   <= nbr_s2;
		tile_s3  <= tile_s2;
		dist_s3  <= DIST_W'(sq_x_s2) + DIST_W'(sq_y_s2) + DIST_W'(sq_z_s2);
	end

	// strict compare keeps the earlier candidate on a tie
	assign closer = vld_s3 && (first_s3 || (dist_s3 < cd_q));

	always_ff @(posedge clk) begin
		if (closer) begin
			cur_q <= tile_s3;
			cd_q  <= dist_s3;
		end
		if (cmd.out_load) begin
			nearest_q <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moved_q <= 1'b0;
		end else if (cmd.clr_moved) begin
			moved_q <= 1'b0;
		end else if (closer && nbr_s3) begin
			moved_q <= 1'b1;
		end
	end

	assign stat.busy    = vld_s1 | vld_s2 | vld_s3;
	assign stat.moved   = moved_q;
	assign stat.nbr_cnt = cnt_eff;

	assign nearest_tile = nearest_q;

endmodule

`default_nettype wire

// ----- rtl/core/gntw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Controller of the tile walk: seed scan, neighbor hops, output handshake.
// Depends on gntw_pkg.

module gntw_ctrl #(
	parameter int SEED_TILES = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	output logic                 out_valid,
	input  logic                 out_stall,
	output gntw_pkg::gntw_cmd_t  cmd,
	input  gntw_pkg::gntw_stat_t stat
);

	import gntw_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEED   = 3'd1;
	localparam logic [2:0] ST_SDRAIN = 3'd2;
	localparam logic [2:0] ST_NREAD  = 3'd3;
	localparam logic [2:0] ST_NISSUE = 3'd4;
	localparam logic [2:0] ST_NDRAIN = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	localparam logic [SEED_IDX_W-1:0] SEED_LAST = SEED_IDX_W'(SEED_TILES - 1);

	logic [2:0]            state_q, state_d;
	logic [SEED_IDX_W-1:0] seed_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  out_vld_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_QUERY) begin
						cmd.start = 1'b1;
						state_d   = ST_SEED;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_SEED: begin
				cmd.cand_vld   = 1'b1;
				cmd.cand_first = (seed_q == '0);
				cmd.seed_idx   = seed_q;
				if (seed_q == SEED_LAST) begin
					state_d = ST_SDRAIN;
				end
			end
			ST_SDRAIN: begin
				if (!stat.busy) begin
					state_d = ST_NREAD;
				end
			end
			ST_NREAD: begin
				cmd.nbr_rd    = 1'b1;
				cmd.clr_moved = 1'b1;
				state_d       = ST_NISSUE;
			end
			ST_NISSUE: begin
				cmd.cand_vld = 1'b1;
				cmd.cand_nbr = 1'b1;
				cmd.slot     = slot_q;
				if (slot_q == SLOT_W'(stat.nbr_cnt - CNT_W'(1))) begin
					state_d = ST_NDRAIN;
				end
			end
			ST_NDRAIN: begin
				if (!stat.busy) begin
					state_d = stat.moved ? ST_NREAD : ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			seed_q    <= '0;
			slot_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				seed_q <= '0;
			end else if (state_q == ST_SEED) begin
				seed_q <= seed_q + SEED_IDX_W'(1);
			end
			if (cmd.nbr_rd) begin
				slot_q <= '0;
			end else if (state_q == ST_NISSUE) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_vld_q;

endmodule

`default_nettype wire

// ----- rtl/core/greedy_nearest_tile_walk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Greedy nearest tile walk over a geodesic tile grid.
//
// Input channel (in_valid / in_stall): a load transaction (command 0) writes
// one tile's position, neighbor row and neighbor count and gives
// no result. A query transaction (command 1) gives a point; the block scans
// seed tiles 0..SEED_TILES-1, then hops to the nearest neighbor while it is
// strictly closer, and returns the final tile on nearest_tile.
// Output channel (out_valid / out_stall): one transaction per query, held in
// an output register, so loads and the next query are taken while it waits.
// A query first scans the seed tiles and then hops from tile to tile, each
// hop being one neighbor row read, one distance per cycle through the
// distance pipeline, then drain; a walk ends when a hop finds
// no closer tile. in_stall stays high for the whole walk. A finished walk
// waits for the output register to empty when the receiver stalls.
// Reset clears control state only; table contents are undefined until loaded
// and every tile a query reaches must have been loaded first.
// Depends on gntw_pkg, gntw_ctrl, gntw_dp, gntw_ram.

module greedy_nearest_tile_walk #(
	parameter int MAX_NEIGHBORS = 6,
	parameter int SEED_TILES    = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic        [gntw_pkg::TILE_W-1:0]  tile_index,
	input  logic signed [gntw_pkg::POS_W-1:0]   pos_x,
	input  logic signed [gntw_pkg::POS_W-1:0]   pos_y,
	input  logic signed [gntw_pkg::POS_W-1:0]   pos_z,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_0,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_1,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_2,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_3,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_4,
	input  logic        [gntw_pkg::TILE_W-1:0]  neighbor_5,
	input  logic        [gntw_pkg::CNT_W-1:0]   neighbor_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [gntw_pkg::TILE_W-1:0]  nearest_tile
);

	import gntw_pkg::*;

	gntw_cmd_t  cmd;
	gntw_stat_t stat;

	gntw_ctrl #(
		.SEED_TILES (SEED_TILES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	gntw_dp #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.tile_index     (tile_index),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.neighbor_0     (neighbor_0),
		.neighbor_1     (neighbor_1),
		.neighbor_2     (neighbor_2),
		.neighbor_3     (neighbor_3),
		.neighbor_4     (neighbor_4),
		.neighbor_5     (neighbor_5),
		.neighbor_count (neighbor_count),
		.nearest_tile   (nearest_tile)
	);

	a_row_read_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nbr_rd |-> !stat.busy)
		else $error("neighbor row read while distance pipeline busy");

	a_slot_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cand_vld && cmd.cand_nbr) |->
			((stat.nbr_cnt != '0) && (stat.nbr_cnt <= CNT_W'(MAX_NEIGHBORS))))
		else $error("neighbor count out of range during hop");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (command == CMD_QUERY)) |=> !$rose(out_valid))
		else $error("result raised right after query transaction");

endmodule

`default_nettype wire

// ----- sim/greedy_nearest_tile_walk_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for greedy_nearest_tile_walk: loads tile tables, issues
// point queries and compares each nearest_tile against its own walk prediction.
// Depends on gntw_pkg and the greedy_nearest_tile_walk RTL.

module greedy_nearest_tile_walk_tb;
	import gntw_pkg::*;

	localparam int NBR_SLOTS        = 6;
	localparam int SEED_COUNT       = 12;
	localparam int RANDOM_PER_PHASE = 232;
	localparam int MAX_GAP          = 200;
	localparam int DRAIN_CYCLES     = 200;

	typedef struct packed {
		logic                             command;
		logic [TILE_W-1:0]                tile;
		logic signed [POS_W-1:0]          x;
		logic signed [POS_W-1:0]          y;
		logic signed [POS_W-1:0]          z;
		logic [NBR_SLOTS-1:0][TILE_W-1:0] nbr;
		logic [CNT_W-1:0]                 cnt;
	} tile_txn_t;

	class walk_scoreboard;
		logic signed [POS_W-1:0] tile_x[MAX_TILES];
		logic signed [POS_W-1:0] tile_y[MAX_TILES];
		logic signed [POS_W-1:0] tile_z[MAX_TILES];
		logic [TILE_W-1:0]       tile_nbr[MAX_TILES][NBR_SLOTS];
		logic [CNT_W-1:0]        tile_cnt[MAX_TILES];
		logic [TILE_W-1:0]       expected_tiles[$];
		int                      mismatches = 0;

		function longint unsigned sq_dist(logic signed [POS_W-1:0] px, py, pz,
				logic [TILE_W-1:0] t);
			longint dx, dy, dz;
			dx = longint'(px) - longint'(tile_x[t]);
			dy = longint'(py) - longint'(tile_y[t]);
			dz = longint'(pz) - longint'(tile_z[t]);
			return dx * dx + dy * dy + dz * dz;
		endfunction

		function logic [TILE_W-1:0] walk_to_nearest(logic signed [POS_W-1:0] px, py, pz);
			logic [TILE_W-1:0] here, best, cand;
			longint unsigned   d_here, d_best, d_cand;
			int                n;
			bit                moved;
			here   = '0;
			d_here = sq_dist(px, py, pz, here);
			for (int i = 1; i < SEED_COUNT; i++) begin
				cand   = TILE_W'(i);
				d_cand = sq_dist(px, py, pz, cand);
				if (d_cand < d_here) begin
					here   = cand;
					d_here = d_cand;
				end
			end
			moved = 1'b1;
			while (moved) begin
				moved  = 1'b0;
				n      = int'(tile_cnt[here]);
				if (n < 1)
					n = 1;
				if (n > NBR_SLOTS)
					n = NBR_SLOTS;
				best   = tile_nbr[here][0];
				d_best = sq_dist(px, py, pz, best);
				for (int i = 1; i < n; i++) begin
					cand   = tile_nbr[here][i];
					d_cand = sq_dist(px, py, pz, cand);
					if (d_cand < d_best) begin
						best   = cand;
						d_best = d_cand;
					end
				end
				if (d_best < d_here) begin
					here   = best;
					d_here = d_best;
					moved  = 1'b1;
				end
			end
			return here;
		endfunction

		function void note_transaction(tile_txn_t c);
			if (c.command == CMD_LOAD) begin
				tile_x[c.tile]   = c.x;
				tile_y[c.tile]   = c.y;
				tile_z[c.tile]   = c.z;
				tile_cnt[c.tile] = c.cnt;
				for (int j = 0; j < NBR_SLOTS; j++)
					tile_nbr[c.tile][j] = c.nbr[j];
			end else begin
				expected_tiles.push_back(walk_to_nearest(c.x, c.y, c.z));
			end
		endfunction

		function void check_result(logic [TILE_W-1:0] got);
			logic [TILE_W-1:0] want;
			if (expected_tiles.size() == 0) begin
				$display("%0t: unexpected nearest_tile, expected none, got %0d", $time, got);
				mismatches++;
			end else begin
				want = expected_tiles.pop_front();
				if (got !== want) begin
					$display("%0t: nearest_tile mismatch, expected %0d, got %0d",
						$time, want, got);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    in_valid       = 1'b0;
	logic                    in_stall;
	logic                    command        = CMD_LOAD;
	logic [TILE_W-1:0]       tile_index     = '0;
	logic signed [POS_W-1:0] pos_x          = '0;
	logic signed [POS_W-1:0] pos_y          = '0;
	logic signed [POS_W-1:0] pos_z          = '0;
	logic [TILE_W-1:0]       neighbor_0     = '0;
	logic [TILE_W-1:0]       neighbor_1     = '0;
	logic [TILE_W-1:0]       neighbor_2     = '0;
	logic [TILE_W-1:0]       neighbor_3     = '0;
	logic [TILE_W-1:0]       neighbor_4     = '0;
	logic [TILE_W-1:0]       neighbor_5     = '0;
	logic [CNT_W-1:0]        neighbor_count = '0;
	logic                    out_valid;
	logic                    out_stall      = 1'b0;
	logic [TILE_W-1:0]       nearest_tile;

	walk_scoreboard    sb = new();
	logic [TILE_W-1:0] tile_pool[$];
	bit                pooled[MAX_TILES];
	int                tx_idle_pct  = 0;
	int                rx_stall_pct = 0;

	greedy_nearest_tile_walk dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(nearest_tile);
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	task automatic send_transaction(input tile_txn_t c);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= c.command;
		tile_index     <= c.tile;
		pos_x          <= c.x;
		pos_y          <= c.y;
		pos_z          <= c.z;
		neighbor_0     <= c.nbr[0];
		neighbor_1     <= c.nbr[1];
		neighbor_2     <= c.nbr[2];
		neighbor_3     <= c.nbr[3];
		neighbor_4     <= c.nbr[4];
		neighbor_5     <= c.nbr[5];
		neighbor_count <= c.cnt;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_transaction(c);
	endtask

	function automatic void mark_pooled(logic [TILE_W-1:0] idx);
		if (!pooled[idx]) begin
			pooled[idx] = 1'b1;
			tile_pool.push_back(idx);
		end
	endfunction

	function automatic logic signed [POS_W-1:0] rand_coord();
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0:       return POS_W'(-131072);
				1:       return POS_W'(131071);
				2:       return '0;
				default: return '1;
			endcase
		end
		return POS_W'($urandom);
	endfunction

	// Used slots only point at tiles already in the pool, so no walk reads an
	// unwritten entry; unused slots carry random indices.
	task automatic load_tile(input logic [TILE_W-1:0] idx,
			input logic signed [POS_W-1:0] x, y, z,
			input logic [CNT_W-1:0] n, input int first_nbr);
		tile_txn_t c;
		int        used;
		used      = (n == 0) ? 1 : ((int'(n) > NBR_SLOTS) ? NBR_SLOTS : int'(n));
		c.command = CMD_LOAD;
		c.tile    = idx;
		c.x       = x;
		c.y       = y;
		c.z       = z;
		c.cnt     = n;
		for (int j = 0; j < NBR_SLOTS; j++)
			c.nbr[j] = (j < used) ? tile_pool[$urandom_range(tile_pool.size() - 1)]
				: TILE_W'($urandom);
		if (first_nbr >= 0)
			c.nbr[0] = TILE_W'(first_nbr);
		send_transaction(c);
		mark_pooled(idx);
	endtask

	task automatic send_query(input logic signed [POS_W-1:0] x, y, z);
		tile_txn_t c;
		c.command = CMD_QUERY;
		c.tile    = TILE_W'($urandom);
		c.x       = x;
		c.y       = y;
		c.z       = z;
		c.cnt     = CNT_W'($urandom);
		for (int j = 0; j < NBR_SLOTS; j++)
			c.nbr[j] = TILE_W'($urandom);
		send_transaction(c);
	endtask

	task automatic random_item();
		logic [TILE_W-1:0]       idx;
		logic signed [POS_W-1:0] x, y, z;
		logic [CNT_W-1:0]        n;
		int                      kind, jit;
		if ($urandom_range(99) < 35) begin
			if ($urandom_range(1))
				idx = tile_pool[$urandom_range(tile_pool.size() - 1)];
			else
				idx = TILE_W'($urandom_range(MAX_TILES - 1));
			n = ($urandom_range(6) == 0) ? CNT_W'($urandom_range(7))
				: CNT_W'($urandom_range(5, 6));
			load_tile(idx, rand_coord(), rand_coord(), rand_coord(), n, -1);
		end else begin
			kind = $urandom_range(9);
			if (kind < 4) begin
				send_query(rand_coord(), rand_coord(), rand_coord());
			end else begin
				idx = tile_pool[$urandom_range(tile_pool.size() - 1)];
				jit = (kind < 8) ? 1000 : 0;
				x   = POS_W'(int'(sb.tile_x[idx]) + int'($urandom_range(2 * jit)) - jit);
				y   = POS_W'(int'(sb.tile_y[idx]) + int'($urandom_range(2 * jit)) - jit);
				z   = POS_W'(int'(sb.tile_z[idx]) + int'($urandom_range(2 * jit)) - jit);
				send_query(x, y, z);
			end
		end
	endtask

	initial begin
		logic signed [POS_W-1:0] x, y, z;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// seeds plus one far index; tiles 2 and 3 share a position, tile 11 leads to 8191
		for (int i = 0; i < SEED_COUNT; i++)
			mark_pooled(TILE_W'(i));
		mark_pooled(TILE_W'(MAX_TILES - 1));
		load_tile(TILE_W'(MAX_TILES - 1), 900, 900, 900, 6, -1);
		for (int i = 0; i < SEED_COUNT; i++) begin
			if (i == 0) begin
				x = -131072; y = -131072; z = -131072;
			end else if (i == 1) begin
				x = 131071; y = 131071; z = 131071;
			end else if (i == 2 || i == 3) begin
				x = -5000; y = 7000; z = 12345;
			end else if (i == SEED_COUNT - 1) begin
				x = 1000; y = 1000; z = 1000;
			end else begin
				x = POS_W'($urandom); y = POS_W'($urandom); z = POS_W'($urandom);
			end
			load_tile(TILE_W'(i), x, y, z, CNT_W'(i % 8),
				(i == SEED_COUNT - 1) ? MAX_TILES - 1 : -1);
		end
		send_query(-131072, -131072, -131072);
		send_query(131071, 131071, 131071);
		send_query(131071, -131072, 0);
		send_query(-5000, 7000, 12345);
		send_query(900, 900, 900);
		send_query(0, 0, 0);
		send_query(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
		send_query(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
				default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
			endcase
			repeat (RANDOM_PER_PHASE) random_item();
		end
		in_valid <= 1'b0;

		while (sb.expected_tiles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/gntw_pkg.sv
rtl/core/gntw_ram.sv
rtl/core/gntw_dp.sv
rtl/core/gntw_ctrl.sv
rtl/core/greedy_nearest_tile_walk.sv
sim/greedy_nearest_tile_walk_tb.sv
